// ===== sv/v2c_pkg.sv =====
// ----------------------------------------------------------------------------
// v2c_pkg: shared types and constants for the valid-mode 2D filter
// Register indexes, command codes, size limits and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package v2c_pkg;
  localparam int unsigned MaxCols = 1024;
  localparam int unsigned MaxRows = 1024;
  localparam int unsigned MaxKernelDim = 8;
  localparam int unsigned SampleBits = 16;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CoefW = 16;
  localparam int unsigned SumW = 38;
  localparam int unsigned PosW = 10;
  localparam int unsigned KIdxW = 6;
  localparam int unsigned KDepth = 64;
  localparam int unsigned InTDataW = ((KIdxW + CoefW + SampleBits + 7) / 8) * 8;

  localparam logic [CfgIdxW-1:0] RegImageRows = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageCols = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKernelRows = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKernelCols = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFlipKernel = 3'd4;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdSample = 1'b1;
endpackage
`default_nettype wire

// ===== sv/valid_2d_convolution.sv =====
// ----------------------------------------------------------------------------
// valid_2d_convolution: streaming valid-mode 2D filter
// Kernel store, line store and one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Items on the slave side are either coefficient loads (cmd 0) or image
// samples (cmd 1) in raster order. A load, or a sample that completes no
// window, is taken and gives nothing. A sample that completes a window
// makes the sequencer walk the kernel taps through one multiply-accumulate
// unit, one tap per cycle, through the single read port of the line store;
// each tap is read, multiplied and accumulated, and the sum is then handed
// to the output register. The result sits in that register; the next item
// is taken while it waits, and a new result waits only until the register
// is free. Neither store is cleared by reset; unloaded coefficients are
// undefined.
`default_nettype none
module valid_2d_convolution (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [v2c_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [v2c_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: coeff_index[5:0], coefficient[21:6], sample[37:22], zero fill
  input  wire logic [v2c_pkg::InTDataW-1:0] s_axis_tdata,
  // tuser: cmd
  input  wire logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tdata: out_row[9:0], out_col[19:10], sum[57:20]
  output logic [63:0] m_axis_tdata,
  output logic m_axis_tlast
);
  localparam int unsigned ColW = (v2c_pkg::MaxCols > 1) ? $clog2(v2c_pkg::MaxCols) : 1;
  localparam int unsigned KdW =
    (v2c_pkg::MaxKernelDim > 1) ? $clog2(v2c_pkg::MaxKernelDim) : 1;
  localparam int unsigned CntW = 13; // holds config range and counts
  localparam int unsigned LbDepth = v2c_pkg::MaxKernelDim * v2c_pkg::MaxCols;
  localparam int unsigned LbAw = (LbDepth > 1) ? $clog2(LbDepth) : 1;
  localparam int unsigned ProdW = v2c_pkg::SampleBits + v2c_pkg::CoefW;

  typedef enum logic [2:0] {StIdle, StStart, StRun, StDrain, StAcc, StOut} state_e;

  // configuration registers
  logic [10:0] img_rows_q, img_cols_q;
  logic [3:0] ker_rows_q, ker_cols_q;
  logic flip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_rows_q <= 11'd8;
      img_cols_q <= 11'd8;
      ker_rows_q <= 4'd3;
      ker_cols_q <= 4'd3;
      flip_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        v2c_pkg::RegImageRows: img_rows_q <= cfg_data_i;
        v2c_pkg::RegImageCols: img_cols_q <= cfg_data_i;
        v2c_pkg::RegKernelRows: ker_rows_q <= cfg_data_i[3:0];
        v2c_pkg::RegKernelCols: ker_cols_q <= cfg_data_i[3:0];
        v2c_pkg::RegFlipKernel: flip_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [CntW-1:0] rows, cols, kr, kc;
  always_comb begin
    rows = (img_rows_q == 11'd0) ? CntW'(1) :
           (CntW'(img_rows_q) > CntW'(v2c_pkg::MaxRows)) ? CntW'(v2c_pkg::MaxRows)
                                                         : CntW'(img_rows_q);
    cols = (img_cols_q == 11'd0) ? CntW'(1) :
           (CntW'(img_cols_q) > CntW'(v2c_pkg::MaxCols)) ? CntW'(v2c_pkg::MaxCols)
                                                         : CntW'(img_cols_q);
    kr = (ker_rows_q == 4'd0) ? CntW'(1) :
         (CntW'(ker_rows_q) > CntW'(v2c_pkg::MaxKernelDim)) ? CntW'(v2c_pkg::MaxKernelDim)
                                                            : CntW'(ker_rows_q);
    kc = (ker_cols_q == 4'd0) ? CntW'(1) :
         (CntW'(ker_cols_q) > CntW'(v2c_pkg::MaxKernelDim)) ? CntW'(v2c_pkg::MaxKernelDim)
                                                            : CntW'(ker_cols_q);
  end

  // input fields
  logic in_cmd;
  logic [v2c_pkg::KIdxW-1:0] in_kidx;
  logic signed [v2c_pkg::CoefW-1:0] in_coef;
  logic signed [v2c_pkg::SampleBits-1:0] in_samp;
  assign in_cmd = s_axis_tuser;
  assign in_kidx = s_axis_tdata[v2c_pkg::KIdxW-1:0];
  assign in_coef = s_axis_tdata[v2c_pkg::KIdxW +: v2c_pkg::CoefW];
  assign in_samp = s_axis_tdata[v2c_pkg::KIdxW + v2c_pkg::CoefW +: v2c_pkg::SampleBits];

  state_e state_q;
  logic [CntW-1:0] row_q, col_q;       // raster position of next sample
  logic [CntW-1:0] top_q, left_q;
  logic [KdW:0] ki_q, kj_q;            // tap being addressed
  logic last_q, tap_v_q, prod_v_q;
  logic signed [v2c_pkg::SampleBits-1:0] lb_rd_q;
  logic signed [v2c_pkg::CoefW-1:0] k_rd_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [v2c_pkg::SumW-1:0] acc_q;
  logic out_v_q;
  logic [63:0] out_data_q;
  logic out_last_q;
  logic [LbAw-1:0] lb_waddr, lb_raddr;
  logic [CntW-1:0] kidx_full;

  // memories
  logic signed [v2c_pkg::CoefW-1:0] kmem [v2c_pkg::KDepth];
  logic signed [v2c_pkg::SampleBits-1:0] lbmem [LbDepth];
  logic kwe, lbwe;

  // sample and coefficient of the addressed tap are read in the same cycle
  always_ff @(posedge clk_i) begin
    if (kwe) kmem[in_kidx] <= in_coef;
    if (lbwe) lbmem[lb_waddr] <= in_samp;
    lb_rd_q <= lbmem[lb_raddr];
    k_rd_q <= kmem[kidx_full[v2c_pkg::KIdxW-1:0]];
  end

  logic accept;
  assign s_axis_tready = (state_q == StIdle);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign kwe = accept && (in_cmd == v2c_pkg::CmdLoad);
  assign lbwe = accept && (in_cmd == v2c_pkg::CmdSample);

  // window check for the incoming sample
  logic hit;
  assign hit = (kr <= rows) && (kc <= cols) && (row_q < rows) && (col_q < cols) &&
               (row_q + 1'b1 >= kr) && (col_q + 1'b1 >= kc);

  // write address of current sample
  always_comb begin
    lb_waddr = LbAw'(32'(row_q[KdW-1:0]) * v2c_pkg::MaxCols + 32'(col_q[ColW-1:0]));
  end

  // tap addressing
  logic [CntW-1:0] tr, tc, kir, kjc;
  always_comb begin
    tr = top_q + CntW'(ki_q);
    tc = left_q + CntW'(kj_q);
    lb_raddr = LbAw'(32'(tr[KdW-1:0]) * v2c_pkg::MaxCols + 32'(tc[ColW-1:0]));
    kir = flip_q ? (kr - 1'b1 - CntW'(ki_q)) : CntW'(ki_q);
    kjc = flip_q ? (kc - 1'b1 - CntW'(kj_q)) : CntW'(kj_q);
  end
  assign kidx_full = CntW'(kir[KdW:0]) * CntW'(kc[KdW:0]) + kjc;

  logic tap_last;
  assign tap_last = (CntW'(ki_q) == kr - 1'b1) && (CntW'(kj_q) == kc - 1'b1);

  // result moves to the output register once that register is free
  logic out_load;
  assign out_load = (state_q == StOut) && (!out_v_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q <= '0;
      col_q <= '0;
      out_v_q <= 1'b0;
      tap_v_q <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      if (out_load) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
      // MAC pipe: read -> multiply -> accumulate
      prod_v_q <= tap_v_q;
      prod_q <= lb_rd_q * k_rd_q;
      if (prod_v_q) begin
        acc_q <= acc_q + {{(v2c_pkg::SumW - ProdW){prod_q[ProdW-1]}}, prod_q};
      end else if (state_q == StStart) begin
        acc_q <= '0;
      end
      unique case (state_q)
        StIdle: begin
          tap_v_q <= 1'b0;
          if (lbwe) begin
            if (col_q + 1'b1 >= cols) begin
              col_q <= '0;
              row_q <= (row_q + 1'b1 >= rows) ? '0 : row_q + 1'b1;
            end else begin
              col_q <= col_q + 1'b1;
            end
            if (hit) begin
              top_q <= row_q + 1'b1 - kr;
              left_q <= col_q + 1'b1 - kc;
              last_q <= (row_q + 1'b1 == rows) && (col_q + 1'b1 == cols);
              ki_q <= '0;
              kj_q <= '0;
              state_q <= StStart;
            end
          end
        end
        StStart: begin
          tap_v_q <= 1'b1;
          if (tap_last) state_q <= StDrain;
          else begin
            state_q <= StRun;
            if (CntW'(kj_q) == kc - 1'b1) begin
              kj_q <= '0;
              ki_q <= ki_q + 1'b1;
            end else kj_q <= kj_q + 1'b1;
          end
        end
        StRun: begin
          if (tap_last) state_q <= StDrain;
          else if (CntW'(kj_q) == kc - 1'b1) begin
            kj_q <= '0;
            ki_q <= ki_q + 1'b1;
          end else kj_q <= kj_q + 1'b1;
        end
        StDrain: begin
          tap_v_q <= 1'b0;
          state_q <= StAcc;
        end
        StAcc: begin
          if (!prod_v_q && !tap_v_q) state_q <= StOut;
        end
        StOut: begin
          if (out_load) begin
            out_data_q <= 64'({acc_q, left_q[v2c_pkg::PosW-1:0], top_q[v2c_pkg::PosW-1:0]});
            out_last_q <= last_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tlast = out_last_q;
endmodule
`default_nettype wire
